/* hw/rtl/bpp_pkg.sv */
package bpp_pkg;

  localparam int FRAC = 16;

  typedef logic signed [31:0] w32_t;
  typedef logic signed [63:0] w64_t;

  // Particle mode codes
  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BWD  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Register indexes
  localparam int         CFG_IDX_W = 3;
  localparam logic [2:0] REG_MAG_X = 3'd0;
  localparam logic [2:0] REG_MAG_Y = 3'd1;
  localparam logic [2:0] REG_MAG_Z = 3'd2;
  localparam logic [2:0] REG_DT    = 3'd3;
  localparam logic [2:0] REG_BOX   = 3'd4;

  localparam int          LEN_W   = 31;
  localparam logic [30:0] DT_RST  = 31'd6554;
  localparam logic [30:0] BOX_RST = 31'd4194304;

  localparam int IN_W  = 288;
  localparam int OUT_W = 192;
  localparam int USR_W = 3;

  // Rotation factor divide: denominator, numerator and quotient widths
  localparam int DD_W  = 48;
  localparam int NUM_W = 49;
  localparam int QB_B  = 18;
  // Wrap modulo: magnitude width and quotient bits
  localparam int MAG_W = 48;
  localparam int QB_M  = 48;

  function automatic w64_t sx64(w32_t a);
    w64_t r;
    r = a;
    return r;
  endfunction

  // floor(x / 2^16 + 0.5)
  function automatic w64_t rnd16(w64_t x);
    return (x + w64_t'(32768)) >>> FRAC;
  endfunction

  function automatic w64_t smul(w32_t a, w32_t b);
    w64_t x;
    w64_t y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic w32_t sat_w(w64_t x, int eff);
    w64_t hi;
    w64_t lo;
    hi = (w64_t'(1) <<< (eff - 1)) - w64_t'(1);
    lo = -hi - w64_t'(1);
    if (x > hi) return hi[31:0];
    if (x < lo) return lo[31:0];
    return x[31:0];
  endfunction

  function automatic logic [31:0] absu(w32_t a);
    logic signed [32:0] t;
    t = a;
    if (a[31]) t = -t;
    return t[31:0];
  endfunction

endpackage

/* hw/rtl/bpp_div.sv */
module bpp_div #(
  parameter int NW = 49,
  parameter int DW = 48,
  parameter int QB = 18
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = (NW > DW) ? NW : DW;

  logic [NW-1:0] r_q [QB];
  logic [DW-1:0] d_q [QB];
  logic [QB-1:0] q_q [QB];
  logic [NW-1:0] r_c [QB];
  logic [DW-1:0] d_c [QB];
  logic [QB-1:0] q_c [QB];
  logic [NW-1:0] r_d [QB];
  logic [QB-1:0] q_d [QB];

  // One quotient bit per stage, most significant first; the numerator is
  // known to stay below den * 2^QB.
  always_comb begin
    r_c[0] = num_i;
    d_c[0] = den_i;
    q_c[0] = '0;
    for (int g = 1; g < QB; g++) begin
      r_c[g] = r_q[g-1];
      d_c[g] = d_q[g-1];
      q_c[g] = q_q[g-1];
    end
    for (int g = 0; g < QB; g++) begin
      if (CW'(r_c[g] >> (QB - 1 - g)) >= CW'(d_c[g])) begin
        r_d[g] = r_c[g] - NW'(CW'(d_c[g]) << (QB - 1 - g));
        q_d[g] = q_c[g] | (QB'(1) << (QB - 1 - g));
      end else begin
        r_d[g] = r_c[g];
        q_d[g] = q_c[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < QB; g++) begin
        r_q[g] <= r_d[g];
        d_q[g] <= d_c[g];
        q_q[g] <= q_d[g];
      end
    end
  end

  assign quot_o = q_q[QB-1];
  assign rem_o  = DW'(r_q[QB-1]);

endmodule

/* hw/rtl/boris_particle_push_unit.sv */
// Boris particle pusher, one particle per beat, signed Q16.16 throughout.
// Each input beat carries a particle (position, velocity, charge-to-mass
// ratio) and the electric field Ex/Ey gathered at it; the unit applies a half
// electric kick, the rotation about the constant magnetic field in the
// mag_x/y/z registers, and a second half kick. Mode 0 is a full step of
// time_step followed by a position advance, x and y wrapped into
// [0, box_length) by a positive modulo (no wrap when box_length is zero);
// modes 1 and 2 push the velocity only over +dt/2 or -dt/2 and keep the
// position. Inactive particles and mode 3 pass through untouched. Every
// intermediate Q16.16 value but the exact x and y position sums saturates
// to WORD_BITS (at most 32) signed bits. Throughput is one particle per
// clock unless the output stalls; the 18-stage divider forms the rotation
// factors and the 48-stage modulo wraps x and y. The pipeline moves as one:
// it holds only while a finished output beat is offered and not taken, and
// input is refused in exactly those cycles. Write registers only while the
// unit is empty; they are read live by the pipeline.
module boris_particle_push_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // charge_mass, pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in,
  // efield_x, efield_y (32 bits each, from bit 0 up)
  input  logic [bpp_pkg::IN_W-1:0]        s_axis_tdata,
  // mode [1:0], active [2]
  input  logic [bpp_pkg::USR_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out
  // (32 bits each, from bit 0 up)
  output logic [bpp_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);

  import bpp_pkg::*;

  localparam int EFF = (WORD_BITS > 32) ? 32 : WORD_BITS;

  // Stage map
  localparam int S_K    = 1;   // k = 0.5*qm*h
  localparam int S_KP   = 2;   // k*B, k*E products
  localparam int S_AE   = 3;   // a, e
  localparam int S_SQ   = 4;   // a^2 products, v-
  localparam int S_D    = 5;   // denominator, first cross products
  localparam int S_DIVB = 6;   // first cross, divide numerators
  localparam int S_B    = S_DIVB + QB_B + 1;  // v', b
  localparam int S_X2   = S_B + 1;
  localparam int S_C2   = S_X2 + 1;
  localparam int S_VN   = S_C2 + 1;
  localparam int S_STP  = S_VN + 1;
  localparam int S_SUM  = S_STP + 1;
  localparam int S_MAG  = S_SUM + 1;
  localparam int S_OUT  = S_MAG + QB_M + 1;
  localparam int LAST   = S_OUT;

  typedef struct packed {
    logic [1:0]       mode;
    logic             act;
    logic             go;
    w32_t             qm;
    w32_t             px;
    w32_t             py;
    w32_t             pz;
    w32_t             vx;
    w32_t             vy;
    w32_t             vz;
    w32_t             efx;
    w32_t             efy;
    w64_t             m0;
    w64_t             m1;
    w64_t             m2;
    w64_t             m3;
    w64_t             m4;
    w64_t             m5;
    w32_t             k;
    w32_t             ax;
    w32_t             ay;
    w32_t             az;
    w32_t             ex;
    w32_t             ey;
    w32_t             vmx;
    w32_t             vmy;
    w32_t             vmz;
    w32_t             cx;
    w32_t             cy;
    w32_t             cz;
    w32_t             bx;
    w32_t             by;
    w32_t             bz;
    w32_t             vpx;
    w32_t             vpy;
    w32_t             vpz;
    w32_t             nvx;
    w32_t             nvy;
    w32_t             nvz;
    logic [DD_W-1:0]  dd;
    logic [NUM_W-1:0] numx;
    logic [NUM_W-1:0] numy;
    logic [NUM_W-1:0] numz;
    w64_t             sx;
    w64_t             sy;
    w32_t             zo;
    logic [MAG_W-1:0] magx;
    logic [MAG_W-1:0] magy;
  } pkt_t;

  // Configuration
  w32_t             mag_x_q;
  w32_t             mag_y_q;
  w32_t             mag_z_q;
  logic [LEN_W-1:0] time_step_q;
  logic [LEN_W-1:0] box_length_q;
  w32_t             dts;

  // Pipeline
  logic [LAST:0] v_q;
  pkt_t          s_q [LAST+1];
  logic          en;
  pkt_t          in_d, k_d, kp_d, ae_d, sq_d, dn_d, c1_d;
  pkt_t          b_d, x2_d, c2_d, vn_d, stp_d, sum_d, mag_d, out_d;
  logic [QB_B-1:0]  quot_x, quot_y, quot_z;
  logic [LEN_W-1:0] rem_x, rem_y;

  function automatic w32_t mulf(w64_t p);
    return sat_w(rnd16(p), EFF);
  endfunction

  function automatic w32_t adds(w32_t a, w32_t b);
    return sat_w(sx64(a) + sx64(b), EFF);
  endfunction

  function automatic w32_t crossf(w64_t p, w64_t q);
    return sat_w(sx64(mulf(p)) - sx64(mulf(q)), EFF);
  endfunction

  function automatic w32_t signq(logic neg, logic [QB_B-1:0] q);
    w64_t t;
    t = w64_t'({{(64-QB_B){1'b0}}, q});
    if (neg) t = -t;
    return t[31:0];
  endfunction

  // Positive modulo from the magnitude remainder; no wrap for a zero box
  function automatic w32_t wrapf(w64_t s, logic [LEN_W-1:0] rem);
    logic [LEN_W-1:0] r;
    if (box_length_q == '0) return sat_w(s, EFF);
    r = (s[63] && rem != '0) ? box_length_q - rem : rem;
    return sat_w(w64_t'({{(64-LEN_W){1'b0}}, r}), EFF);
  endfunction

  assign dts = w32_t'({1'b0, time_step_q});

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_x_q      <= '0;
      mag_y_q      <= '0;
      mag_z_q      <= '0;
      time_step_q  <= DT_RST;
      box_length_q <= BOX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAG_X: mag_x_q      <= cfg_data_i;
        REG_MAG_Y: mag_y_q      <= cfg_data_i;
        REG_MAG_Z: mag_z_q      <= cfg_data_i;
        REG_DT:    time_step_q  <= cfg_data_i[LEN_W-1:0];
        REG_BOX:   box_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output beat is stuck
  assign en            = !v_q[LAST] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAST];

  // Capture the particle and start qm*dt
  always_comb begin
    in_d      = '0;
    in_d.mode = s_axis_tuser[1:0];
    in_d.act  = s_axis_tuser[2];
    in_d.go   = s_axis_tuser[2] && (s_axis_tuser[1:0] != MODE_NONE);
    in_d.qm   = s_axis_tdata[31:0];
    in_d.px   = s_axis_tdata[63:32];
    in_d.py   = s_axis_tdata[95:64];
    in_d.pz   = s_axis_tdata[127:96];
    in_d.vx   = s_axis_tdata[159:128];
    in_d.vy   = s_axis_tdata[191:160];
    in_d.vz   = s_axis_tdata[223:192];
    in_d.efx  = s_axis_tdata[255:224];
    in_d.efy  = s_axis_tdata[287:256];
    in_d.m0   = smul(s_axis_tdata[31:0], dts);
  end

  // k: round over 17 bits for a full step, 18 for a half step; negate backward
  always_comb begin
    w64_t t;
    w64_t k0;
    k_d = s_q[S_K-1];
    if (k_d.mode == MODE_FULL) begin
      t  = k_d.m0 + w64_t'(65536);
      k0 = t >>> 17;
    end else begin
      t  = k_d.m0 + w64_t'(131072);
      k0 = t >>> 18;
    end
    if (k_d.mode == MODE_BWD) k0 = -k0;
    else if (k_d.mode == MODE_FWD) k0 = k0;
    k_d.k = sat_w(k0, EFF);
  end

  always_comb begin
    kp_d    = s_q[S_KP-1];
    kp_d.m0 = smul(kp_d.k, mag_x_q);
    kp_d.m1 = smul(kp_d.k, mag_y_q);
    kp_d.m2 = smul(kp_d.k, mag_z_q);
    kp_d.m3 = smul(kp_d.k, kp_d.efx);
    kp_d.m4 = smul(kp_d.k, kp_d.efy);
  end

  always_comb begin
    ae_d    = s_q[S_AE-1];
    ae_d.ax = mulf(ae_d.m0);
    ae_d.ay = mulf(ae_d.m1);
    ae_d.az = mulf(ae_d.m2);
    ae_d.ex = mulf(ae_d.m3);
    ae_d.ey = mulf(ae_d.m4);
  end

  // Squares of a, and the first half kick
  always_comb begin
    sq_d     = s_q[S_SQ-1];
    sq_d.m0  = smul(sq_d.ax, sq_d.ax);
    sq_d.m1  = smul(sq_d.ay, sq_d.ay);
    sq_d.m2  = smul(sq_d.az, sq_d.az);
    sq_d.vmx = adds(sq_d.vx, sq_d.ex);
    sq_d.vmy = adds(sq_d.vy, sq_d.ey);
    sq_d.vmz = sat_w(sx64(sq_d.vz), EFF);
  end

  // d = 1 + |a|^2, and the products of v- x a
  always_comb begin
    logic [63:0] ssum;
    dn_d    = s_q[S_D-1];
    ssum    = dn_d.m0 + dn_d.m1 + dn_d.m2 + 64'd32768;
    dn_d.dd = DD_W'(64'd65536 + (ssum >> FRAC));
    dn_d.m0 = smul(dn_d.vmy, dn_d.az);
    dn_d.m1 = smul(dn_d.vmz, dn_d.ay);
    dn_d.m2 = smul(dn_d.vmz, dn_d.ax);
    dn_d.m3 = smul(dn_d.vmx, dn_d.az);
    dn_d.m4 = smul(dn_d.vmx, dn_d.ay);
    dn_d.m5 = smul(dn_d.vmy, dn_d.ax);
  end

  // Finish v- x a; form 2a/(1+|a|^2) numerators with rounding
  always_comb begin
    c1_d      = s_q[S_DIVB-1];
    c1_d.cx   = crossf(c1_d.m0, c1_d.m1);
    c1_d.cy   = crossf(c1_d.m2, c1_d.m3);
    c1_d.cz   = crossf(c1_d.m4, c1_d.m5);
    c1_d.numx = (NUM_W'(absu(c1_d.ax)) << 17) + NUM_W'(c1_d.dd >> 1);
    c1_d.numy = (NUM_W'(absu(c1_d.ay)) << 17) + NUM_W'(c1_d.dd >> 1);
    c1_d.numz = (NUM_W'(absu(c1_d.az)) << 17) + NUM_W'(c1_d.dd >> 1);
  end

  bpp_div #(.NW(NUM_W), .DW(DD_W), .QB(QB_B)) u_div_bx (
    .clk_i (clk_i), .en_i (en), .num_i (s_q[S_DIVB].numx), .den_i (s_q[S_DIVB].dd),
    .quot_o (quot_x), .rem_o ()
  );
  bpp_div #(.NW(NUM_W), .DW(DD_W), .QB(QB_B)) u_div_by (
    .clk_i (clk_i), .en_i (en), .num_i (s_q[S_DIVB].numy), .den_i (s_q[S_DIVB].dd),
    .quot_o (quot_y), .rem_o ()
  );
  bpp_div #(.NW(NUM_W), .DW(DD_W), .QB(QB_B)) u_div_bz (
    .clk_i (clk_i), .en_i (en), .num_i (s_q[S_DIVB].numz), .den_i (s_q[S_DIVB].dd),
    .quot_o (quot_z), .rem_o ()
  );

  // v' = v- + v- x a; b takes the sign of a
  always_comb begin
    b_d     = s_q[S_B-1];
    b_d.vpx = adds(b_d.vmx, b_d.cx);
    b_d.vpy = adds(b_d.vmy, b_d.cy);
    b_d.vpz = adds(b_d.vmz, b_d.cz);
    b_d.bx  = signq(b_d.ax[31], quot_x);
    b_d.by  = signq(b_d.ay[31], quot_y);
    b_d.bz  = signq(b_d.az[31], quot_z);
  end

  always_comb begin
    x2_d    = s_q[S_X2-1];
    x2_d.m0 = smul(x2_d.vpy, x2_d.bz);
    x2_d.m1 = smul(x2_d.vpz, x2_d.by);
    x2_d.m2 = smul(x2_d.vpz, x2_d.bx);
    x2_d.m3 = smul(x2_d.vpx, x2_d.bz);
    x2_d.m4 = smul(x2_d.vpx, x2_d.by);
    x2_d.m5 = smul(x2_d.vpy, x2_d.bx);
  end

  always_comb begin
    c2_d    = s_q[S_C2-1];
    c2_d.cx = crossf(c2_d.m0, c2_d.m1);
    c2_d.cy = crossf(c2_d.m2, c2_d.m3);
    c2_d.cz = crossf(c2_d.m4, c2_d.m5);
  end

  // v+ = v- + v' x b, then the second half kick
  always_comb begin
    vn_d     = s_q[S_VN-1];
    vn_d.nvx = adds(adds(vn_d.vmx, vn_d.cx), vn_d.ex);
    vn_d.nvy = adds(adds(vn_d.vmy, vn_d.cy), vn_d.ey);
    vn_d.nvz = adds(vn_d.vmz, vn_d.cz);
  end

  always_comb begin
    stp_d    = s_q[S_STP-1];
    stp_d.m0 = smul(stp_d.nvx, dts);
    stp_d.m1 = smul(stp_d.nvy, dts);
    stp_d.m2 = smul(stp_d.nvz, dts);
  end

  // Keep x and y sums exact for the wrap; z saturates
  always_comb begin
    sum_d    = s_q[S_SUM-1];
    sum_d.sx = sx64(sum_d.px) + rnd16(sum_d.m0);
    sum_d.sy = sx64(sum_d.py) + rnd16(sum_d.m1);
    sum_d.zo = sat_w(sx64(sum_d.pz) + rnd16(sum_d.m2), EFF);
  end

  always_comb begin
    w64_t nx;
    w64_t ny;
    mag_d      = s_q[S_MAG-1];
    nx         = -mag_d.sx;
    ny         = -mag_d.sy;
    mag_d.magx = mag_d.sx[63] ? nx[MAG_W-1:0] : mag_d.sx[MAG_W-1:0];
    mag_d.magy = mag_d.sy[63] ? ny[MAG_W-1:0] : mag_d.sy[MAG_W-1:0];
  end

  bpp_div #(.NW(MAG_W), .DW(LEN_W), .QB(QB_M)) u_mod_x (
    .clk_i (clk_i), .en_i (en), .num_i (s_q[S_MAG].magx), .den_i (box_length_q),
    .quot_o (), .rem_o (rem_x)
  );
  bpp_div #(.NW(MAG_W), .DW(LEN_W), .QB(QB_M)) u_mod_y (
    .clk_i (clk_i), .en_i (en), .num_i (s_q[S_MAG].magy), .den_i (box_length_q),
    .quot_o (), .rem_o (rem_y)
  );

  // Select results; untouched particles keep their input fields
  always_comb begin
    out_d = s_q[S_OUT-1];
    if (out_d.go) begin
      out_d.vx = out_d.nvx;
      out_d.vy = out_d.nvy;
      out_d.vz = out_d.nvz;
      if (out_d.mode == MODE_FULL) begin
        out_d.px = wrapf(out_d.sx, rem_x);
        out_d.py = wrapf(out_d.sy, rem_y);
        out_d.pz = out_d.zo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], s_axis_tvalid};
    end
  end

  // Plain delay stages copy forward; working stages load their own result
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 1; n <= LAST; n++) begin
        if (!(n inside {[S_K:S_DIVB], [S_B:S_MAG], S_OUT})) begin
          s_q[n] <= s_q[n-1];
        end
      end
      s_q[0]      <= in_d;
      s_q[S_K]    <= k_d;
      s_q[S_KP]   <= kp_d;
      s_q[S_AE]   <= ae_d;
      s_q[S_SQ]   <= sq_d;
      s_q[S_D]    <= dn_d;
      s_q[S_DIVB] <= c1_d;
      s_q[S_B]    <= b_d;
      s_q[S_X2]   <= x2_d;
      s_q[S_C2]   <= c2_d;
      s_q[S_VN]   <= vn_d;
      s_q[S_STP]  <= stp_d;
      s_q[S_SUM]  <= sum_d;
      s_q[S_MAG]  <= mag_d;
      s_q[S_OUT]  <= out_d;
    end
  end

  assign m_axis_tdata = {s_q[LAST].vz, s_q[LAST].vy, s_q[LAST].vx,
                         s_q[LAST].pz, s_q[LAST].py, s_q[LAST].px};

  // A waiting output beat must hold the whole pipe, input included
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output beat waits");

  // Rotation factors stay below 2^17 for a moving particle
  a_rot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[S_B-1] && s_q[S_B-1].go) |->
      (!quot_x[QB_B-1] && !quot_y[QB_B-1] && !quot_z[QB_B-1]))
    else $error("rotation factor out of range");

  // A wrapped position lands inside the box
  a_wrap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && s_q[LAST].go && s_q[LAST].mode == MODE_FULL &&
     box_length_q != '0) |->
      (!s_q[LAST].px[31] && (s_q[LAST].px[30:0] < box_length_q) &&
       !s_q[LAST].py[31] && (s_q[LAST].py[30:0] < box_length_q)))
    else $error("wrapped position outside box");

endmodule

/* tb/sv/boris_particle_push_unit_chk.sv */
`timescale 1ns / 100ps

module boris_particle_push_unit_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [bpp_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic [bpp_pkg::USR_W-1:0]     s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [bpp_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [bpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);

  import bpp_pkg::*;

  typedef struct {
    logic [31:0] fld[6];
  } particle_out_t;

  particle_out_t particle_q[$];
  longint        mag_fld[3];
  longint        dt_q;
  longint        box_q;
  int            shown;

  const string FLD_NAME[6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint wrap_box(longint s);
    longint r;
    if (box_q == 0) return sat32(s);
    r = s % box_q;
    if (r < 0) r += box_q;
    return sat32(r);
  endfunction

  // Boris push of one particle against the current register settings
  function automatic particle_out_t boris_push(logic [1:0] md, logic act,
                                               logic [IN_W-1:0] dat);
    particle_out_t res;
    longint        qm, k, p[3], v[3], e[3], a[3], bf[3], vm[3], vp[3], c[3];
    logic [65:0]   sumsq;
    logic [63:0]   den, mg, quo;
    int            sh;
    qm = longint'($signed(dat[31:0]));
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(dat[32*(1+i) +: 32]));
      v[i] = longint'($signed(dat[32*(4+i) +: 32]));
    end
    if (act && md != MODE_NONE) begin
      sh = (md == MODE_FULL) ? 17 : 18;
      k  = (qm * dt_q + (64'sd1 <<< (sh - 1))) >>> sh;
      if (md == MODE_BWD) k = -k;
      k = sat32(k);
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        a[i]  = qmul(k, mag_fld[i]);
        sumsq += 66'(a[i] * a[i]);
      end
      e[0] = qmul(k, longint'($signed(dat[255:224])));
      e[1] = qmul(k, longint'($signed(dat[287:256])));
      e[2] = 0;
      den = 64'd65536 + 64'((sumsq + 66'd32768) >> 16);
      for (int i = 0; i < 3; i++) begin
        mg    = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
        quo   = ((mg << 17) + den / 2) / den;
        bf[i] = (a[i] < 0) ? -longint'(quo) : longint'(quo);
      end
      for (int i = 0; i < 3; i++) vm[i] = sat32(v[i] + e[i]);
      c[0] = sat32(qmul(vm[1], a[2]) - qmul(vm[2], a[1]));
      c[1] = sat32(qmul(vm[2], a[0]) - qmul(vm[0], a[2]));
      c[2] = sat32(qmul(vm[0], a[1]) - qmul(vm[1], a[0]));
      for (int i = 0; i < 3; i++) vp[i] = sat32(vm[i] + c[i]);
      c[0] = sat32(qmul(vp[1], bf[2]) - qmul(vp[2], bf[1]));
      c[1] = sat32(qmul(vp[2], bf[0]) - qmul(vp[0], bf[2]));
      c[2] = sat32(qmul(vp[0], bf[1]) - qmul(vp[1], bf[0]));
      for (int i = 0; i < 3; i++) v[i] = sat32(sat32(vm[i] + c[i]) + e[i]);
      if (md == MODE_FULL) begin
        for (int i = 0; i < 3; i++) c[i] = (v[i] * dt_q + 64'sd32768) >>> 16;
        p[0] = wrap_box(p[0] + c[0]);
        p[1] = wrap_box(p[1] + c[1]);
        p[2] = sat32(p[2] + c[2]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.fld[i]   = p[i][31:0];
      res.fld[3+i] = v[i][31:0];
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_cnt_o++;
    if (shown < 30) begin
      shown++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
  endtask

  initial begin
    fail_cnt_o = 0;
    shown      = 0;
  end

  assign pending_o = particle_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    particle_out_t want;
    if (!rst_ni) begin
      mag_fld = '{0, 0, 0};
      dt_q    = longint'(DT_RST);
      box_q   = longint'(BOX_RST);
      particle_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAG_X: mag_fld[0] = longint'($signed(cfg_data_i));
          REG_MAG_Y: mag_fld[1] = longint'($signed(cfg_data_i));
          REG_MAG_Z: mag_fld[2] = longint'($signed(cfg_data_i));
          REG_DT:    dt_q       = longint'(cfg_data_i[30:0]);
          REG_BOX:   box_q      = longint'(cfg_data_i[30:0]);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (particle_q.size() == 0) begin
          report("unexpected beat", m_axis_tdata[31:0], '0);
        end else begin
          want = particle_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (m_axis_tdata[32*i +: 32] !== want.fld[i])
              report(FLD_NAME[i], m_axis_tdata[32*i +: 32], want.fld[i]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        particle_q.push_back(boris_push(s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tdata));
    end
  end

endmodule

/* tb/sv/boris_particle_push_unit_tb.sv */
`timescale 1ns / 100ps

module boris_particle_push_unit_tb;
  import bpp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 120;   // comfortably above the pipeline depth

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;   // charge_mass, pos x/y/z, vel x/y/z, efield x/y
  logic [USR_W-1:0]     s_axis_tuser;   // mode [1:0], active [2]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // pos x/y/z, vel x/y/z
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;

  int fail_cnt;
  int pending;
  int sent_cnt;
  int mode_cnt[4];
  int inactive_cnt;
  bit quiet;        // when set, neither side idles
  bit pressed;
  int hold_left;

  boris_particle_push_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  boris_particle_push_unit_chk u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d beats outstanding", CYCLE_LIMIT, pending);
    $display("status: fail");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off to fill the pipe
  initial begin
    m_axis_tready = 1'b0;
    pressed       = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (!pressed && sent_cnt >= 500) begin
        pressed   = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
      end
    end
  end

  // Mostly moderate values so the push does real work; full-range and
  // extreme values keep every bit toggling and hit saturation.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($signed($urandom_range(2097152)) - 1048576);
      4, 5:       return 32'($signed($urandom_range(134217728)) - 67108864);
      6:          return 32'($signed($urandom_range(131072)) - 65536);
      7, 8:       return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  // Offer one particle beat and hold it until accepted
  task automatic send_particle(logic [1:0] md, logic act, logic [IN_W-1:0] dat);
    while (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {act, md};
    s_axis_tdata  <= dat;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
    if (act) mode_cnt[md]++;
    else inactive_cnt++;
  endtask

  task automatic send_random(int n);
    logic [IN_W-1:0] dat;
    logic [1:0]      md;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 9; i++) dat[32*i +: 32] = rand_word();
      md = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
      send_particle(md, $urandom_range(9) != 0, dat);
    end
  endtask

  // Drain the pipe, then write all five registers back to back
  task automatic load_regs(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                           logic [30:0] dt, logic [30:0] box);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= (i == REG_MAG_X) ? bx : (i == REG_MAG_Y) ? by :
                    (i == REG_MAG_Z) ? bz : (i == REG_DT) ? {1'b0, dt} : {1'b0, box};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [IN_W-1:0] dat;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    sent_cnt      = 0;
    inactive_cnt  = 0;
    mode_cnt      = '{0, 0, 0, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings with a field set, then each mode and flag,
    // then all-extreme particles
    load_regs(32'h00010000, 32'hffff8000, 32'h00020000, DT_RST, BOX_RST);
    dat = '0;
    for (int i = 0; i < 9; i++) dat[32*i +: 32] = 32'h00010000 * (i + 1);
    dat[31:0] = 32'h00020000;
    for (int m = 0; m < 4; m++) begin
      send_particle(2'(m), 1'b1, dat);
      send_particle(2'(m), 1'b0, dat);
    end
    for (int m = 0; m < 3; m++) begin
      send_particle(2'(m), 1'b1, {9{32'h7fffffff}});
      send_particle(2'(m), 1'b1, {9{32'h80000000}});
      send_particle(2'(m), 1'b1, '0);
      send_particle(2'(m), 1'b1, {9{32'hffffffff}});
    end
    // Position just below zero and just above the box: wrap both ways
    dat = '0;
    dat[63:32] = 32'hffff0000;
    dat[95:64] = 32'({1'b0, BOX_RST}) + 32'h00008000;
    dat[31:0]  = 32'h00010000;
    send_particle(MODE_FULL, 1'b1, dat);
    send_random(280);

    // Moderate field, pressure stall happens here
    load_regs(32'h00030000, 32'hfffd0000, 32'h00008000, 31'd13107, 31'h00a00000);
    send_random(290);

    // Extreme field, longest step, smallest box; no idling at all
    quiet = 1'b1;
    load_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'd1);
    send_random(290);
    quiet = 1'b0;

    // Zero step and zero box: no push, no wrap
    load_regs(32'h80000000, 32'h00050000, 32'hffff0000, 31'd0, 31'd0);
    send_random(200);

    // Random full-range field, smallest step, largest box
    load_regs($urandom, $urandom, $urandom, 31'd1, 31'h7fffffff);
    send_random(290);

    // Random moderate settings
    load_regs(rand_word(), rand_word(), rand_word(),
              31'($urandom_range(262144)), 31'($urandom_range(1, 31'h7fffffff)));
    send_random(380);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("pushed %0d particles: full %0d, forward %0d, backward %0d, mode 3 %0d, inactive %0d",
             sent_cnt, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], inactive_cnt);
    $display("six register settings incl. extreme field, zero/max step, zero/unit box; %0d errors",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* boris_particle_push_unit.f */
hw/rtl/bpp_pkg.sv
hw/rtl/bpp_div.sv
hw/rtl/boris_particle_push_unit.sv
tb/sv/boris_particle_push_unit_chk.sv
tb/sv/boris_particle_push_unit_tb.sv
